[src/ttg_pkg.sv]
// types, constants and command struct shared by the text terminal grid modules
package ttg_pkg;

    localparam int ROWS   = 24;
    localparam int COLS   = 72;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS = 8'd8;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
        logic cfg_write;
    } ttg_cmd_t;

endpackage

[src/ttg_ctrl.sv]
// sequencing state machine and handshake control for the text terminal grid
module ttg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    output logic            result_valid,
    input  logic            result_stall,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    output ttg_pkg::ttg_cmd_t cmd
);
    import ttg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.cfg_write = cfg_valid;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/ttg_datapath.sv]
// cursor logic, per-row fill counts, grid memory and result register
module ttg_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ttg_pkg::ttg_cmd_t  cmd,
    input  ttg_pkg::in_item_t  item,
    input  logic               cfg_data,
    output ttg_pkg::out_item_t result
);
    import ttg_pkg::*;

    in_item_t          item_reg;
    out_item_t         out_reg;
    logic              enable_reg;
    logic [ROW_W-1:0]  top_reg;
    logic [ROW_W-1:0]  top_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [COL_W-1:0]  fill_reg [ROWS];
    logic [COL_W-1:0]  fill_next;
    logic              scrolled_reg;
    logic              rd_hit_reg;
    logic [CHAR_W-1:0] rdata_reg;
    logic [CHAR_W-1:0] mem [DEPTH];

    logic              is_read;
    logic              put_act;
    logic              is_lf;
    logic              is_bs;
    logic              is_char;
    logic              need_adv;
    logic              at_bottom;
    logic              do_scroll;
    logic              do_write;
    logic [COL_W-1:0]  wcol;
    logic [COL_W-1:0]  wcol_inc;
    logic [ROW_W:0]    rsum;
    logic [ROW_W:0]    wsum;
    logic [ROW_W-1:0]  rphys;
    logic [ROW_W-1:0]  wphys;
    logic              rd_in_range;
    logic [ROW_W-1:0]  idx;
    logic [COL_W-1:0]  col_sel;
    logic [COL_W-1:0]  fill_sel;
    logic [COL_W-1:0]  fill_eff;
    logic              fill_we;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
    logic              rd_hit_next;

    // item decode
    always_comb
    begin
        is_read   = (item_reg.kind == KIND_READ);
        put_act   = !is_read && enable_reg && (item_reg.char_code != CH_CR);
        is_lf     = (item_reg.char_code == CH_LF);
        is_bs     = (item_reg.char_code == CH_BS);
        is_char   = !is_lf && !is_bs;
        need_adv  = is_lf || (is_char && (cur_col_reg == COL_LAST));
        at_bottom = (cur_row_reg == ROW_LAST);
        do_scroll = put_act && need_adv && at_bottom;
        do_write  = put_act && (is_char || (is_bs && (cur_col_reg != '0)));
    end

    // cursor update
    always_comb
    begin
        top_next     = top_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        wcol         = cur_col_reg;
        if (do_scroll)
        begin
            top_next = (top_reg == ROW_LAST) ? '0 : top_reg + ROW_W'(1);
        end
        if (put_act && need_adv)
        begin
            cur_row_next = at_bottom ? cur_row_reg : cur_row_reg + ROW_W'(1);
        end
        if (is_bs)
        begin
            wcol = cur_col_reg - COL_W'(1);
        end
        else if (need_adv)
        begin
            wcol = '0;
        end
        wcol_inc = wcol + COL_W'(1);
        if (put_act)
        begin
            if (is_lf)
            begin
                cur_col_next = '0;
            end
            else if (is_bs)
            begin
                cur_col_next = (cur_col_reg != '0) ? wcol : cur_col_reg;
            end
            else
            begin
                cur_col_next = wcol_inc;
            end
        end
    end

    // visible to physical row mapping
    always_comb
    begin
        rd_in_range = (item_reg.read_row < ROW_W'(ROWS)) && (item_reg.read_col < COL_W'(COLS));
        rsum  = {1'b0, top_reg} + {1'b0, item_reg.read_row};
        rphys = (rsum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rsum - (ROW_W+1)'(ROWS)) : rsum[ROW_W-1:0];
        wsum  = {1'b0, top_next} + {1'b0, cur_row_next};
        wphys = (wsum >= (ROW_W+1)'(ROWS)) ? ROW_W'(wsum - (ROW_W+1)'(ROWS)) : wsum[ROW_W-1:0];
    end

    // fill count and memory access
    always_comb
    begin
        if (is_read)
        begin
            idx     = rd_in_range ? rphys : '0;
            col_sel = rd_in_range ? item_reg.read_col : '0;
        end
        else
        begin
            idx     = wphys;
            col_sel = wcol;
        end
        fill_sel    = fill_reg[idx];
        fill_eff    = do_scroll ? '0 : fill_sel;
        fill_we     = cmd.exec && (do_write || do_scroll);
        fill_next   = '0;
        if (do_write)
        begin
            fill_next = (wcol_inc > fill_eff) ? wcol_inc : fill_eff;
        end
        addr        = ADDR_W'(idx) * ADDR_W'(COLS) + ADDR_W'(col_sel);
        wdata       = is_bs ? '0 : item_reg.char_code;
        rd_hit_next = is_read && rd_in_range && (item_reg.read_col < fill_sel);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (do_write)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            top_reg     <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                enable_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                top_reg     <= top_next;
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
            end
            if (fill_we)
            begin
                fill_reg[idx] <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            scrolled_reg <= do_scroll;
            rd_hit_reg   <= rd_hit_next;
        end
        if (cmd.finish)
        begin
            out_reg.cell_char  <= rd_hit_reg ? rdata_reg : '0;
            out_reg.cursor_row <= cur_row_reg;
            out_reg.cursor_col <= cur_col_reg;
            out_reg.scrolled   <= scrolled_reg;
        end
    end

    assign result = out_reg;

endmodule

[src/text_terminal_grid_top.sv]
// Text terminal character grid: a 24 x 72 byte grid with a cursor, fed one put or read
// beat at a time. Each item passes in turn through the capture of the beat, the single-port
// grid RAM access with the cursor and scroll update, and the load of the result register,
// which waits while the result side is stalled. A new beat is taken once the previous
// item has loaded the result register, while its result still waits there. Scrolling
// keeps a rotating top-row pointer, and each row keeps a fill count of written columns,
// so a scrolled-in row and the grid after reset read as empty at once, with no clearing
// pass. The user writes the enable register through the cfg port only while the block
// is idle; the block itself does not enforce this, and the cfg port is always ready.
module text_terminal_grid_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  ttg_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output ttg_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import ttg_pkg::*;

    ttg_cmd_t cmd;

    ttg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cmd          (cmd)
    );

    ttg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

[verif/text_terminal_grid_top_test.sv]
// testbench for the text terminal grid: directed table plus random console traffic
`timescale 1ns / 1ps

module text_terminal_grid_top_test;
    import ttg_pkg::*;

    localparam int IN_W        = $bits(in_item_t);
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_CFG
    } plan_op_e;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    typedef struct {
        plan_op_e  op;
        logic      cfg_val;
        in_item_t  beat;
        int        reps;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    logic      cfg_valid    = 1'b0;
    logic      cfg_ready;
    logic      cfg_data     = 1'b0;

    // grid predictor state
    logic [CHAR_W-1:0] screen [DEPTH] = '{default: '0};
    logic [ROW_W-1:0]  view_top   = '0;
    logic [ROWS-1:0]   blank_rows = '0;
    logic [ROW_W-1:0]  crs_row    = '0;
    logic [COL_W-1:0]  crs_col    = '0;
    logic              term_enable = 1'b0;

    out_item_t pending_results [$];
    int        mismatches  = 0;
    int        beats_sent  = 0;
    int        burst_left  = 5;
    bit        valid_up    = 1'b0;
    bit        hold_req    = 1'b0;

    localparam int PLAN_LEN = 31;
    plan_row_t plan [PLAN_LEN] = '{
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h41, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd31, 7'd127}, 1, 1'b1,
          '{8'h00, 5'd0, 7'd0, 1'b0}},
        '{OP_CFG, 1'b1, '0, 0, 1'b0, '0},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h41, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd1, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'hFF, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd2, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_CR, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{8'h41, 5'd0, 7'd3, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd0, 7'd1}, 1, 1'b1, '{8'hFF, 5'd0, 7'd3, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd0, 7'd2}, 1, 1'b1, '{8'h00, 5'd0, 7'd3, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_BS, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd0, 7'd2, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_LF, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd1, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_BS, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd1, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd24, 7'd0}, 1, 1'b1,
          '{8'h00, 5'd1, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd0, 7'd72}, 1, 1'b1,
          '{8'h00, 5'd1, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd23, 7'd71}, 1, 1'b1,
          '{8'h00, 5'd1, 7'd0, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h7E, 5'd0, 7'd0}, 71, 1'b0, '0},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h5A, 5'd0, 7'd0}, 1, 1'b0, '0},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_LF, 5'd0, 7'd0}, 21, 1'b0, '0},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_LF, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd23, 7'd0, 1'b1}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h71, 5'd0, 7'd0}, 71, 1'b0, '0},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h57, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd23, 7'd1, 1'b1}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd23, 7'd0}, 1, 1'b1,
          '{8'h57, 5'd23, 7'd1, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd22, 7'd70}, 1, 1'b1,
          '{8'h71, 5'd23, 7'd1, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd0, 7'd0}, 1, 1'b0, '0},
        '{OP_CFG, 1'b0, '0, 0, 1'b0, '0},
        '{OP_BEAT, 1'b0, '{KIND_PUT, 8'h42, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd23, 7'd1, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_PUT, CH_LF, 5'd0, 7'd0}, 1, 1'b1, '{8'h00, 5'd23, 7'd1, 1'b0}},
        '{OP_BEAT, 1'b0, '{KIND_READ, 8'h00, 5'd23, 7'd0}, 1, 1'b1,
          '{8'h57, 5'd23, 7'd1, 1'b0}},
        '{OP_CFG, 1'b1, '0, 0, 1'b0, '0}
    };

    text_terminal_grid_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int phys_of(int vis);
        return (int'(view_top) + vis) % ROWS;
    endfunction

    function automatic void store_cell(int vis, int col, logic [CHAR_W-1:0] v);
        int p;
        p = phys_of(vis % ROWS);
        if (col >= COLS)
            return;
        if (blank_rows[p])
        begin
            for (int c = 0; c < COLS; c++)
                screen[p * COLS + c] = '0;
            blank_rows[p] = 1'b0;
        end
        screen[p * COLS + col] = v;
    endfunction

    function automatic logic [CHAR_W-1:0] fetch_cell(int vis, int col);
        int p;
        if (vis >= ROWS || col >= COLS)
            return '0;
        p = phys_of(vis);
        if (blank_rows[p])
            return '0;
        return screen[p * COLS + col];
    endfunction

    // cursor to column 0 of the next row, scrolling off the bottom
    function automatic bit next_line();
        crs_col = '0;
        if (int'(crs_row) + 1 >= ROWS)
        begin
            blank_rows[view_top] = 1'b1;
            view_top = ROW_W'((int'(view_top) + 1) % ROWS);
            crs_row = ROW_LAST;
            return 1'b1;
        end
        crs_row = crs_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        r = '0;
        if (it.kind == KIND_READ)
            r.cell_char = fetch_cell(int'(it.read_row), int'(it.read_col));
        else if (term_enable && it.char_code != CH_CR)
        begin
            if (it.char_code == CH_LF)
                r.scrolled = next_line();
            else if (it.char_code == CH_BS)
            begin
                if (crs_col != '0)
                begin
                    crs_col = crs_col - 1'b1;
                    store_cell(int'(crs_row), int'(crs_col), '0);
                end
            end
            else
            begin
                if (crs_col >= COL_LAST)
                    r.scrolled = next_line();
                store_cell(int'(crs_row), int'(crs_col), it.char_code);
                crs_col = crs_col + 1'b1;
            end
        end
        r.cursor_row = crs_row;
        r.cursor_col = crs_col;
        return r;
    endfunction

    function automatic in_item_t make_put(logic [CHAR_W-1:0] ch);
        in_item_t b;
        b = in_item_t'(IN_W'($urandom));
        b.kind = KIND_PUT;
        b.char_code = ch;
        return b;
    endfunction

    function automatic in_item_t make_read(int row, int col);
        in_item_t b;
        b = in_item_t'(IN_W'($urandom));
        b.kind = KIND_READ;
        b.read_row = ROW_W'(row);
        b.read_col = COL_W'(col);
        return b;
    endfunction

    task automatic offer_beat(input in_item_t it, input bit typed = 1'b0,
                              input out_item_t want = '0);
        out_item_t guess;
        item <= it;
        item_valid <= 1'b1;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        guess = predict_result(it);
        pending_results.push_back(typed ? want : guess);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            item_valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain_results();
        if (valid_up)
        begin
            item_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_enable(input logic v);
        drain_results();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        term_enable = v;
    endtask

    task automatic run_phase(input int n_items);
        int start, len, pick, sel, cnt;
        bit paused;
        logic [CHAR_W-1:0] ch;
        start = beats_sent;
        paused = 1'b0;
        while (beats_sent - start < n_items)
        begin
            if (!paused && beats_sent - start >= n_items / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // one line of text, sometimes long enough to wrap
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(68, 76)
                                                  : $urandom_range(0, 30);
                for (int k = 0; k < len; k++)
                begin
                    sel = $urandom_range(0, 39);
                    if (sel == 0)
                        ch = CH_BS;
                    else if (sel == 1)
                        ch = CH_CR;
                    else if (sel < 5)
                        ch = CHAR_W'($urandom);
                    else
                        ch = CHAR_W'($urandom_range(32, 126));
                    offer_beat(make_put(ch));
                end
                if ($urandom_range(0, 4) != 0)
                    offer_beat(make_put(CH_LF));
            end
            else if (pick < 80)
            begin
                cnt = $urandom_range(1, 4);
                for (int k = 0; k < cnt; k++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        offer_beat(make_read($urandom_range(0, 31), $urandom_range(0, 127)));
                    else if (sel < 4)
                        offer_beat(make_read(int'(crs_row), $urandom_range(0, COLS - 1)));
                    else
                        offer_beat(make_read($urandom_range(0, ROWS - 1),
                                             $urandom_range(0, COLS - 1)));
                end
            end
            else if (pick < 90)
            begin
                cnt = $urandom_range(1, 5);
                for (int k = 0; k < cnt; k++)
                    offer_beat(make_put(CH_BS));
            end
            else
                offer_beat(in_item_t'(IN_W'($urandom)));
        end
    endtask

    // result side: the stall pattern switches between randomly drawn modes, with one long hold-off
    initial
    begin
        stall_mode_e mode;
        int left;
        @(posedge rst_n);
        forever
        begin
            mode = stall_mode_e'($urandom_range(0, 3));
            left = $urandom_range(16, 96);
            while (left > 0)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    result_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    STALL_NONE:  result_stall <= 1'b0;
                    STALL_LIGHT: result_stall <= ($urandom_range(0, 9) < 3);
                    STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
                    default:     result_stall <= (left % 3 == 0);
                endcase
                left--;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: char %02h row %0d col %0d scr %0b",
                             result.cell_char, result.cursor_row, result.cursor_col,
                             result.scrolled);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want)
                begin
                    if (mismatches < 10)
                        $display({"mismatch: expected char %02h row %0d col %0d scr %0b,",
                                  " got char %02h row %0d col %0d scr %0b"},
                                 want.cell_char, want.cursor_row, want.cursor_col,
                                 want.scrolled, result.cell_char, result.cursor_row,
                                 result.cursor_col, result.scrolled);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == OP_CFG)
                set_enable(plan[i].cfg_val);
            else
                for (int r = 0; r < plan[i].reps; r++)
                    offer_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        drain_results();
        hold_req = 1'b1;
        run_phase(160);
        set_enable(1'b0);
        run_phase(30);
        set_enable(1'b1);
        run_phase(160);
        set_enable(1'b0);
        run_phase(30);
        set_enable(1'b1);
        run_phase(140);

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
